>>> src/imutcf_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package imutcf_pkg;

  localparam int CORDIC_STEPS_DEF = 16;

  localparam int CFG_IDX_W = 8;
  localparam logic [CFG_IDX_W-1:0] REG_BLEND_ALPHA = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GYRO_GAIN   = 8'd1;

  localparam logic [15:0] ALPHA_RESET = 16'd64225;
  localparam logic [31:0] GAIN_RESET  = 32'd109951163;

  localparam int ROOT_W = 24;
  localparam int RAD_W  = 48;
  localparam int XY_W   = 28;
  localparam int Z_W    = 32;

  localparam int MA_W = 36;
  localparam int MB_W = 33;
  localparam int MP_W = 69;

  localparam logic signed [MB_W-1:0] DEG_MUL = 33'sd60078979;
  localparam logic signed [MP_W-1:0] HALF16  = {{(MP_W-16){1'b0}}, 1'b1, 15'b0};
  localparam logic signed [MP_W-1:0] HALF32  = {{(MP_W-32){1'b0}}, 1'b1, 31'b0};
  localparam logic signed [MP_W-1:0] SAT_MAX = {{(MP_W-31){1'b0}}, {31{1'b1}}};
  localparam logic signed [MP_W-1:0] SAT_MIN = {{(MP_W-31){1'b1}}, 31'b0};

  function automatic logic signed [Z_W-1:0] atan_lut(input logic [4:0] idx);
    logic signed [Z_W-1:0] v;
    unique case (idx)
      5'd0:  v = 32'sd843314856;
      5'd1:  v = 32'sd497837829;
      5'd2:  v = 32'sd263043836;
      5'd3:  v = 32'sd133525158;
      5'd4:  v = 32'sd67021686;
      5'd5:  v = 32'sd33543515;
      5'd6:  v = 32'sd16775850;
      5'd7:  v = 32'sd8388437;
      5'd8:  v = 32'sd4194282;
      5'd9:  v = 32'sd2097149;
      5'd10: v = 32'sd1048575;
      5'd11: v = 32'sd524287;
      5'd12: v = 32'sd262143;
      5'd13: v = 32'sd131071;
      5'd14: v = 32'sd65535;
      5'd15: v = 32'sd32767;
      5'd16: v = 32'sd16383;
      5'd17: v = 32'sd8191;
      5'd18: v = 32'sd4095;
      5'd19: v = 32'sd2047;
      5'd20: v = 32'sd1023;
      5'd21: v = 32'sd511;
      5'd22: v = 32'sd255;
      5'd23: v = 32'sd127;
      5'd24: v = 32'sd63;
      5'd25: v = 32'sd31;
      5'd26: v = 32'sd15;
      5'd27: v = 32'sd8;
      5'd28: v = 32'sd4;
      5'd29: v = 32'sd2;
      5'd30: v = 32'sd1;
      default: v = 32'sd0;
    endcase
    return v;
  endfunction

endpackage
`default_nettype wire

>>> src/imutcf_if.sv
`timescale 1ns / 1ps
`default_nettype none
interface imutcf_in_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] accel_x;
  logic signed [15:0] accel_y;
  logic signed [15:0] accel_z;
  logic signed [15:0] gyro_x;
  logic signed [15:0] gyro_y;
  modport source (output valid, accel_x, accel_y, accel_z, gyro_x, gyro_y, input ready);
  modport sink (input valid, accel_x, accel_y, accel_z, gyro_x, gyro_y, output ready);
endinterface

interface imutcf_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] pitch_deg;
  logic signed [31:0] roll_deg;
  modport source (output valid, pitch_deg, roll_deg, input ready);
  modport sink (input valid, pitch_deg, roll_deg, output ready);
endinterface

interface imutcf_cfg_if;
  logic        valid;
  logic        ready;
  logic [7:0]  index;
  logic [31:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

>>> src/imutcf_mul.sv
`timescale 1ns / 1ps
`default_nettype none
module imutcf_mul import imutcf_pkg::*; (
  input  wire logic                   clk,
  input  wire logic signed [MA_W-1:0] a,
  input  wire logic signed [MB_W-1:0] b,
  output logic signed [MP_W-1:0]      p_r
);

  logic signed [MP_W-1:0] p_nxt;

  assign p_nxt = MP_W'(a) * MP_W'(b);

  always_ff @(posedge clk) begin
    p_r <= p_nxt;
  end

endmodule
`default_nettype wire

>>> src/imutcf_sqrt.sv
`timescale 1ns / 1ps
`default_nettype none
module imutcf_sqrt import imutcf_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              start,
  input  wire logic [RAD_W-1:0]  n,
  output logic                   done_r,
  output logic [ROOT_W-1:0]      root_r
);

  logic [RAD_W-1:0]  n_r;
  logic [ROOT_W+1:0] rem_r;
  logic [4:0]        cnt_r;
  logic              busy_r;
  logic [ROOT_W+3:0] rem_sh;
  logic [ROOT_W+3:0] trial;

  assign rem_sh = {rem_r, n_r[RAD_W-1 -: 2]};
  assign trial  = {2'b00, root_r, 2'b01};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        n_r    <= n;
        rem_r  <= '0;
        root_r <= '0;
        cnt_r  <= '0;
      end else if (busy_r) begin
        n_r <= {n_r[RAD_W-3:0], 2'b00};
        if (rem_sh >= trial) begin
          rem_r  <= (ROOT_W+2)'(rem_sh - trial);
          root_r <= {root_r[ROOT_W-2:0], 1'b1};
        end else begin
          rem_r  <= rem_sh[ROOT_W+1:0];
          root_r <= {root_r[ROOT_W-2:0], 1'b0};
        end
        cnt_r <= cnt_r + 5'd1;
        if (cnt_r == 5'(ROOT_W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

endmodule
`default_nettype wire

>>> src/imutcf_cordic.sv
`timescale 1ns / 1ps
`default_nettype none
module imutcf_cordic import imutcf_pkg::*; #(
  parameter int STEPS = CORDIC_STEPS_DEF
) (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic                     start,
  input  wire logic [ROOT_W-1:0]        x0,
  input  wire logic signed [ROOT_W-1:0] y0,
  output logic                          done_r,
  output logic signed [31:0]            angle_r
);

  localparam int IW = $clog2(STEPS);

  logic signed [XY_W-1:0] x_r, y_r, dx, dy, x_nxt, y_nxt;
  logic signed [Z_W-1:0]  z_r, z_nxt;
  logic signed [Z_W:0]    z_rnd;
  logic [IW-1:0]          i_r;
  logic                   busy_r;
  logic                   zero_r;

  always_comb begin
    dx = x_r >>> i_r;
    dy = y_r >>> i_r;
    if (!y_r[XY_W-1]) begin
      x_nxt = x_r + dy;
      y_nxt = y_r - dx;
      z_nxt = z_r + atan_lut(5'(i_r));
    end else begin
      x_nxt = x_r - dy;
      y_nxt = y_r + dx;
      z_nxt = z_r - atan_lut(5'(i_r));
    end
    z_rnd = ((Z_W+1)'(z_nxt) + 33'sd2) >>> 2;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        x_r    <= $signed({{(XY_W-ROOT_W){1'b0}}, x0});
        y_r    <= XY_W'(y0);
        z_r    <= '0;
        i_r    <= '0;
        zero_r <= (x0 == '0) && (y0 == '0);
      end else if (busy_r) begin
        x_r <= x_nxt;
        y_r <= y_nxt;
        z_r <= z_nxt;
        i_r <= i_r + IW'(1);
        if (i_r == IW'(STEPS - 1)) begin
          busy_r  <= 1'b0;
          done_r  <= 1'b1;
          angle_r <= zero_r ? 32'sd0 : z_rnd[31:0];
        end
      end
    end
  end

endmodule
`default_nettype wire

>>> src/imu_tilt_complementary_filter_core.sv
`timescale 1ns / 1ps
`default_nettype none
// Port     Dir  Payload
// in_ch    in   accel_x, accel_y, accel_z, gyro_x, gyro_y (s16)
// out_ch   out  pitch_deg, roll_deg (s Q16.16 degrees)
// cfg_ch   in   index (0 blend_alpha, 1 gyro_gain), data
// Each angle runs a 24-step bit-pair square root, then the CORDIC, then the
// blend and degree scaling, which use the one shared multiplier.
// in_ch.ready is high only while idle; a finished result waits in the
// output register, and the next item is taken while it waits.
// Reset is synchronous: kept angles go to zero, registers to their defaults.
module imu_tilt_complementary_filter_core import imutcf_pkg::*; #(
  parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
  input  wire logic     clk,
  input  wire logic     rst_n,
  imutcf_in_if.sink     in_ch,
  imutcf_out_if.source  out_ch,
  imutcf_cfg_if.sink    cfg_ch
);

  typedef enum logic [3:0] {
    ST_IDLE, ST_SQ, ST_SQRT_GO, ST_SQRT_WAIT, ST_CORD_WAIT,
    ST_B_INC, ST_B_SUM, ST_B_MA, ST_B_MB, ST_B_SAT, ST_B_DEG, ST_B_DST, ST_DONE
  } state_t;

  state_t state_r;

  logic [15:0]            alpha_r;
  logic [31:0]            gain_r;
  logic signed [15:0]     ax_r, ay_r, az_r, gx_r, gy_r;
  logic [30:0]            sx_r, sy_r, sz_r;
  logic [1:0]             cnt_r;
  logic                   pass_r;
  logic signed [31:0]     tilt_r, pitch_r, roll_r, pdeg_r, rdeg_r, cur_ang;
  logic signed [MA_W-1:0] sum_r;
  logic signed [MP_W-1:0] acc_r, p_r, inc_full, v_full, d_full;
  logic signed [MA_W-1:0] mul_a;
  logic signed [MB_W-1:0] mul_b;
  logic signed [16:0]     rate;
  logic [16:0]            wacc;
  logic [31:0]            sq_sum;
  logic signed [15:0]     num;
  logic                   sq_done, cd_done;
  logic [ROOT_W-1:0]      root;
  logic signed [31:0]     cd_angle;
  logic                   out_valid_r;
  logic signed [31:0]     out_pitch_r, out_roll_r;
  logic signed [31:0]     sat_ang;

  assign in_ch.ready     = (state_r == ST_IDLE);
  assign cfg_ch.ready    = 1'b1;
  assign out_ch.valid    = out_valid_r;
  assign out_ch.pitch_deg = out_pitch_r;
  assign out_ch.roll_deg  = out_roll_r;

  assign cur_ang  = pass_r ? roll_r : pitch_r;
  assign num      = pass_r ? ay_r : ax_r;
  assign sq_sum   = pass_r ? (32'(sx_r) + 32'(sz_r)) : (32'(sy_r) + 32'(sz_r));
  assign rate     = pass_r ? 17'(gx_r) : -17'(gy_r);
  assign wacc     = 17'h10000 - {1'b0, alpha_r};
  assign inc_full = (p_r + HALF16) >>> 16;
  assign v_full   = (acc_r + p_r + HALF16) >>> 16;
  assign d_full   = (p_r + HALF32) >>> 32;

  always_comb begin
    if (v_full > SAT_MAX) begin
      sat_ang = 32'sh7fffffff;
    end else if (v_full < SAT_MIN) begin
      sat_ang = 32'sh80000000;
    end else begin
      sat_ang = v_full[31:0];
    end
  end

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state_r)
      ST_SQ: begin
        unique case (cnt_r)
          2'd0: begin
            mul_a = MA_W'(ax_r);
            mul_b = MB_W'(ax_r);
          end
          2'd1: begin
            mul_a = MA_W'(ay_r);
            mul_b = MB_W'(ay_r);
          end
          2'd2: begin
            mul_a = MA_W'(az_r);
            mul_b = MB_W'(az_r);
          end
          default: begin
            mul_a = '0;
            mul_b = '0;
          end
        endcase
      end
      ST_B_INC: begin
        mul_a = MA_W'(rate);
        mul_b = $signed({1'b0, gain_r});
      end
      ST_B_MA: begin
        mul_a = sum_r;
        mul_b = $signed({17'b0, alpha_r});
      end
      ST_B_MB: begin
        mul_a = MA_W'(tilt_r);
        mul_b = $signed({16'b0, wacc});
      end
      ST_B_DEG: begin
        mul_a = MA_W'(cur_ang);
        mul_b = DEG_MUL;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  imutcf_mul u_mul (
    .clk (clk),
    .a   (mul_a),
    .b   (mul_b),
    .p_r (p_r)
  );

  imutcf_sqrt u_sqrt (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (state_r == ST_SQRT_GO),
    .n      ({sq_sum, 16'b0}),
    .done_r (sq_done),
    .root_r (root)
  );

  imutcf_cordic #(.STEPS(CORDIC_STEPS)) u_cordic (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   ((state_r == ST_SQRT_WAIT) && sq_done),
    .x0      (root),
    .y0      ({num, 8'b0}),
    .done_r  (cd_done),
    .angle_r (cd_angle)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      alpha_r <= ALPHA_RESET;
      gain_r  <= GAIN_RESET;
    end else if (cfg_ch.valid) begin
      if (cfg_ch.index == REG_BLEND_ALPHA) begin
        alpha_r <= cfg_ch.data[15:0];
      end else if (cfg_ch.index == REG_GYRO_GAIN) begin
        gain_r <= cfg_ch.data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      pitch_r     <= '0;
      roll_r      <= '0;
      out_valid_r <= 1'b0;
      cnt_r       <= '0;
      pass_r      <= 1'b0;
    end else begin
      if (out_valid_r && out_ch.ready && (state_r != ST_DONE)) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        ST_IDLE: begin
          if (in_ch.valid) begin
            ax_r    <= in_ch.accel_x;
            ay_r    <= in_ch.accel_y;
            az_r    <= in_ch.accel_z;
            gx_r    <= in_ch.gyro_x;
            gy_r    <= in_ch.gyro_y;
            cnt_r   <= '0;
            pass_r  <= 1'b0;
            state_r <= ST_SQ;
          end
        end
        ST_SQ: begin
          cnt_r <= cnt_r + 2'd1;
          unique case (cnt_r)
            2'd1: sx_r <= p_r[30:0];
            2'd2: sy_r <= p_r[30:0];
            2'd3: begin
              sz_r    <= p_r[30:0];
              state_r <= ST_SQRT_GO;
            end
            default: ;
          endcase
        end
        ST_SQRT_GO: state_r <= ST_SQRT_WAIT;
        ST_SQRT_WAIT: begin
          if (sq_done) begin
            state_r <= ST_CORD_WAIT;
          end
        end
        ST_CORD_WAIT: begin
          if (cd_done) begin
            tilt_r  <= cd_angle;
            state_r <= ST_B_INC;
          end
        end
        ST_B_INC: state_r <= ST_B_SUM;
        ST_B_SUM: begin
          sum_r   <= MA_W'(cur_ang) + MA_W'(inc_full);
          state_r <= ST_B_MA;
        end
        ST_B_MA: state_r <= ST_B_MB;
        ST_B_MB: begin
          acc_r   <= p_r;
          state_r <= ST_B_SAT;
        end
        ST_B_SAT: begin
          if (pass_r) begin
            roll_r <= sat_ang;
          end else begin
            pitch_r <= sat_ang;
          end
          state_r <= ST_B_DEG;
        end
        ST_B_DEG: state_r <= ST_B_DST;
        ST_B_DST: begin
          if (pass_r) begin
            rdeg_r  <= d_full[31:0];
            state_r <= ST_DONE;
          end else begin
            pdeg_r  <= d_full[31:0];
            pass_r  <= 1'b1;
            state_r <= ST_SQRT_GO;
          end
        end
        ST_DONE: begin
          if (!out_valid_r || out_ch.ready) begin
            out_valid_r <= 1'b1;
            out_pitch_r <= pdeg_r;
            out_roll_r  <= rdeg_r;
            state_r     <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ch.ready) |=> !in_ch.ready)
    else $error("input taken while an item is in work");

  a_result_from_done: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_ch.valid) |-> $past(state_r == ST_DONE))
    else $error("result shown without finishing an item");

  a_cordic_done_waited: assert property (@(posedge clk) disable iff (!rst_n)
    cd_done |-> (state_r == ST_CORD_WAIT))
    else $error("cordic finished outside its wait state");
`endif

endmodule
`default_nettype wire

>>> test/imu_tilt_complementary_filter_core_test.sv
`timescale 1ns / 1ps
module imu_tilt_complementary_filter_core_test;
  import imutcf_pkg::*;

  localparam int STEPS = 16;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE = 8'd2;
  localparam logic [CFG_IDX_W-1:0] REG_TOP = 8'hFF;
  localparam int STALL_LIMIT = 4000;
  localparam int HOLD_CYCLES = 500;
  localparam int DRAIN_CYCLES = 150;

  typedef struct {
    logic signed [31:0] pitch;
    logic signed [31:0] roll;
  } tilt_result_t;

  class tilt_board;
    logic [15:0] alpha;
    logic [31:0] gain;
    logic signed [31:0] pitch_q;
    logic signed [31:0] roll_q;
    tilt_result_t expq[$];
    int errors;
    longint atan_q30[32];

    function void init();
      atan_q30 = '{843314856, 497837829, 263043836, 133525158, 67021686, 33543515,
                   16775850, 8388437, 4194282, 2097149, 1048575, 524287, 262143,
                   131071, 65535, 32767, 16383, 8191, 4095, 2047, 1023, 511, 255,
                   127, 63, 31, 15, 8, 4, 2, 1, 0};
      alpha = ALPHA_RESET;
      gain = GAIN_RESET;
      pitch_q = 0;
      roll_q = 0;
      errors = 0;
    endfunction

    function void report(string msg);
      $display("mismatch: %s", msg);
      errors++;
    endfunction

    function void write_reg(logic [7:0] idx, logic [31:0] data);
      if (idx == REG_BLEND_ALPHA) alpha = data[15:0];
      else if (idx == REG_GYRO_GAIN) gain = data;
    endfunction

    function longint root(longint n_in);
      bit [63:0] n, res, b;
      n = n_in;
      res = 0;
      b = 64'd1 << 62;
      while (b > n) b = b >> 2;
      while (b != 0) begin
        if (n >= res + b) begin
          n = n - (res + b);
          res = (res >> 1) + b;
        end else begin
          res = res >> 1;
        end
        b = b >> 2;
      end
      return longint'(res);
    endfunction

    function longint tilt(longint num, longint sq);
      longint x, y, z, dx, dy;
      x = root(sq << 16);
      y = num * 256;
      z = 0;
      if (x == 0 && y == 0) return 0;
      for (int i = 0; i < STEPS; i++) begin
        dx = x >>> i;
        dy = y >>> i;
        if (y >= 0) begin
          x += dy;
          y -= dx;
          z += atan_q30[i];
        end else begin
          x -= dy;
          y += dx;
          z -= atan_q30[i];
        end
      end
      return (z + 2) >>> 2;
    endfunction

    function logic signed [31:0] blend(logic signed [31:0] ang, longint rate, longint acc);
      longint inc, sum, a, v;
      inc = (rate * longint'(gain) + 32768) >>> 16;
      sum = longint'(ang) + inc;
      a = longint'(alpha);
      v = (a * sum + (65536 - a) * acc + 32768) >>> 16;
      if (v > 64'sd2147483647) v = 64'sd2147483647;
      if (v < -64'sd2147483648) v = -64'sd2147483648;
      return v[31:0];
    endfunction

    function logic signed [31:0] degrees(logic signed [31:0] ang);
      longint d;
      d = (longint'(ang) * 60078979 + (64'sd1 <<< 31)) >>> 32;
      return d[31:0];
    endfunction

    function void note_sample(logic signed [15:0] ax, ay, az, gx, gy);
      longint pa, ra;
      tilt_result_t r;
      pa = tilt(ax, longint'(ay) * ay + longint'(az) * az);
      ra = tilt(ay, longint'(ax) * ax + longint'(az) * az);
      pitch_q = blend(pitch_q, -longint'(gy), pa);
      roll_q = blend(roll_q, longint'(gx), ra);
      r.pitch = degrees(pitch_q);
      r.roll = degrees(roll_q);
      expq.push_back(r);
    endfunction

    function void check_result(logic signed [31:0] p, logic signed [31:0] r);
      tilt_result_t e;
      if (expq.size() == 0) begin
        report($sformatf("unexpected result pitch %0d roll %0d", p, r));
        return;
      end
      e = expq.pop_front();
      if (p !== e.pitch) report($sformatf("pitch got %0d want %0d", p, e.pitch));
      if (r !== e.roll) report($sformatf("roll got %0d want %0d", r, e.roll));
    endfunction
  endclass

  logic clk;
  logic rst_n;
  imutcf_in_if in_ch();
  imutcf_out_if out_ch();
  imutcf_cfg_if cfg_ch();
  tilt_board board;
  bit hold_req;
  bit burst;
  int idle_cycles;

  imu_tilt_complementary_filter_core u_dut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch), .cfg_ch(cfg_ch)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  initial begin
    board = new();
    board.init();
    rst_n <= 1'b0;
    in_ch.valid <= 1'b0;
    in_ch.accel_x <= '0;
    in_ch.accel_y <= '0;
    in_ch.accel_z <= '0;
    in_ch.gyro_x <= '0;
    in_ch.gyro_y <= '0;
    out_ch.ready <= 1'b0;
    cfg_ch.valid <= 1'b0;
    cfg_ch.index <= '0;
    cfg_ch.data <= '0;
  end

  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready)
      board.check_result(out_ch.pitch_deg, out_ch.roll_deg);
  end

  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready) || !rst_n) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("** imu_tilt_complementary_filter_core: FAILED **");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    int n;
    @(posedge rst_n);
    forever begin
      if (hold_req) begin
        out_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_req = 1'b0;
      end
      n = burst ? 0 : $urandom_range(0, 10);
      if (n > 0) begin
        out_ch.ready <= 1'b0;
        repeat (n) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (!out_ch.valid);
    end
  end

  task automatic send_sample(logic signed [15:0] ax, ay, az, gx, gy);
    int n;
    n = burst ? 0 : $urandom_range(0, 10);
    if (n > 0) begin
      in_ch.valid <= 1'b0;
      repeat (n) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.accel_x <= ax;
    in_ch.accel_y <= ay;
    in_ch.accel_z <= az;
    in_ch.gyro_x <= gx;
    in_ch.gyro_y <= gy;
    do @(posedge clk); while (!in_ch.ready);
    board.note_sample(ax, ay, az, gx, gy);
  endtask

  task automatic drain();
    in_ch.valid <= 1'b0;
    while (board.expq.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [7:0] idx, logic [31:0] data);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data <= data;
    do @(posedge clk); while (!cfg_ch.ready);
    board.write_reg(idx, data);
    cfg_ch.valid <= 1'b0;
    @(posedge clk);
  endtask

  function automatic logic [15:0] pick_field();
    case ($urandom_range(0, 5))
      0: return 16'h8000;
      1: return 16'h7FFF;
      2: return 16'(signed'($urandom_range(0, 64)) - 32);
      3: return 16'(signed'($urandom_range(0, 4096)) - 2048);
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic send_random(int count);
    for (int i = 0; i < count; i++) begin
      if (i % 60 == 0) burst = ($urandom_range(0, 3) == 0);
      send_sample(pick_field(), pick_field(), pick_field(), pick_field(), pick_field());
    end
    burst = 1'b0;
  endtask

  task automatic directed();
    send_sample(0, 0, 0, 0, 0);
    send_sample(0, 0, 0, 16'sh7FFF, 16'sh8000);
    send_sample(16'sh7FFF, 0, 0, 0, 0);
    send_sample(16'sh8000, 0, 0, 0, 0);
    send_sample(0, 16'sh7FFF, 0, 0, 0);
    send_sample(0, 16'sh8000, 0, 0, 0);
    send_sample(0, 0, 16'sh7FFF, 0, 0);
    send_sample(0, 0, 16'sh8000, 0, 0);
    send_sample(16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh7FFF);
    send_sample(16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'sh8000);
    send_sample(1, -1, 16384, -1, 1);
    send_sample(16'shFFFF, 16'shFFFF, 16'shFFFF, 16'shFFFF, 16'shFFFF);
  endtask

  initial begin
    logic [31:0] a, g;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    directed();
    drain();

    write_reg(REG_BLEND_ALPHA, 32'hFFFF_FFFF);
    write_reg(REG_GYRO_GAIN, 32'hFFFF_FFFF);
    write_reg(REG_SPARE, 32'h0000_0000);
    write_reg(REG_TOP, 32'h1234_5678);
    for (int i = 0; i < 8; i++) send_sample(0, 0, 0, 16'sh8000, 16'sh8000);
    for (int i = 0; i < 8; i++) send_sample(0, 0, 0, 16'sh7FFF, 16'sh7FFF);
    drain();

    write_reg(REG_BLEND_ALPHA, 32'hABCD_0000);
    write_reg(REG_GYRO_GAIN, 32'h0);
    directed();
    drain();

    write_reg(REG_BLEND_ALPHA, 32'(ALPHA_RESET));
    write_reg(REG_GYRO_GAIN, GAIN_RESET);
    hold_req = 1'b1;
    send_random(30);
    drain();

    for (int ph = 0; ph < 10; ph++) begin
      case (ph % 4)
        0: a = 32'($urandom_range(60000, 65535));
        1: a = 32'($urandom_range(0, 65535));
        2: a = (ph < 5) ? 32'h0 : 32'hFFFF;
        default: a = $urandom;
      endcase
      case (ph % 3)
        0: g = $urandom_range(0, 400000000);
        1: g = $urandom;
        default: g = (ph < 5) ? 32'h0 : 32'hFFFF_FFFF;
      endcase
      write_reg(REG_BLEND_ALPHA, a);
      write_reg(REG_GYRO_GAIN, g);
      send_random(140);
      drain();
    end

    if (board.errors == 0) begin
      $display("** imu_tilt_complementary_filter_core: PASSED **");
    end else begin
      $display("** imu_tilt_complementary_filter_core: FAILED **");
    end
    $finish;
  end
endmodule
